// ===== src/sbpb_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpb_pkg
// Shared types and constants of the soft brush pixel blend.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpb_pkg;

  // Fixed field widths.
  localparam int RADW = 14;
  localparam int CHW  = 8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_HARD_RADIUS = 3'd3,
    REG_BRUSH_RED   = 3'd4,
    REG_BRUSH_GREEN = 3'd5,
    REG_BRUSH_BLUE  = 3'd6,
    REG_BRUSH_ALPHA = 3'd7
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [RADW-1:0] RADIUS_RST      = 14'd80;
  localparam logic [RADW-1:0] HARD_RADIUS_RST = 14'd0;
  localparam logic [CHW-1:0]  BRUSH_RED_RST   = 8'd35;
  localparam logic [CHW-1:0]  BRUSH_GREEN_RST = 8'd97;
  localparam logic [CHW-1:0]  BRUSH_BLUE_RST  = 8'd20;
  localparam logic [CHW-1:0]  BRUSH_ALPHA_RST = 8'd255;

  // How the opacity of a pixel is chosen.
  typedef enum logic [1:0] {
    OP_ZERO = 2'd0,
    OP_ONE  = 2'd1,
    OP_DIV  = 2'd2
  } op_mode_t;

  // Request data that rides along with the arithmetic.
  typedef struct packed {
    logic [CHW-1:0] dst_r;
    logic [CHW-1:0] dst_g;
    logic [CHW-1:0] dst_b;
    logic [CHW-1:0] dst_a;
    logic           written;
    op_mode_t       mode;
  } side_t;

endpackage

`default_nettype wire

// ===== src/soft_brush_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// soft_brush_pixel_blend
// Soft round brush: blends one RGBA pixel toward the brush color per request.
// ----------------------------------------------------------------------------
//  Channel  Direction  Protocol            Carries
//  in_      slave      tvalid/tready/data  pixel position and existing RGBA
//  out_     master     tvalid/tready/data  blended RGBA, written flag in tuser
//  cfg_     write      we/index/wdata      brush center, radii and color
//
//  One request enters every cycle that the pipeline advances. It has
//  COORD_WIDTH+RADIUS_FRAC_BITS+1 square root cells, OPACITY_FRAC_BITS divider
//  cells and six stages. The whole pipeline advances together; it holds only
//  while a finished result waits at the output and out_tready is low.
//  Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_brush_pixel_blend
  import sbpb_pkg::*;
#(
  parameter int COORD_WIDTH       = 13,
  parameter int RADIUS_FRAC_BITS  = 4,
  parameter int OPACITY_FRAC_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // pixel_x, pixel_y, dest_red, dest_green, dest_blue, dest_alpha, zero pad
  input  wire logic [((2*COORD_WIDTH+4*8+7)/8)*8-1:0] in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [4*8-1:0]             out_tdata,
  // written
  output logic                       out_tuser,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [(COORD_WIDTH > 14 ? COORD_WIDTH : 14)-1:0] cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int F    = OPACITY_FRAC_BITS;
  localparam int RW   = CW + 1 + RADIUS_FRAC_BITS;
  localparam int SQW  = 2 * RW;
  localparam int NW   = (RW > RADW ? RW : RADW) + 1;
  localparam int PW   = F + 11;
  localparam int ACCW = F + 12;

  // --------------------------------------------------------------------------
  // Configuration registers.
  logic signed [CW-1:0] center_x_r, center_y_r;
  logic [RADW-1:0]      radius_r, hard_r;
  logic [CHW-1:0]       br_r, bg_r, bb_r, ba_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      radius_r   <= RADIUS_RST;
      hard_r     <= HARD_RADIUS_RST;
      br_r       <= BRUSH_RED_RST;
      bg_r       <= BRUSH_GREEN_RST;
      bb_r       <= BRUSH_BLUE_RST;
      ba_r       <= BRUSH_ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:    center_x_r <= cfg_wdata[CW-1:0];
        REG_CENTER_Y:    center_y_r <= cfg_wdata[CW-1:0];
        REG_RADIUS:      radius_r   <= cfg_wdata[RADW-1:0];
        REG_HARD_RADIUS: hard_r     <= cfg_wdata[RADW-1:0];
        REG_BRUSH_RED:   br_r       <= cfg_wdata[CHW-1:0];
        REG_BRUSH_GREEN: bg_r       <= cfg_wdata[CHW-1:0];
        REG_BRUSH_BLUE:  bb_r       <= cfg_wdata[CHW-1:0];
        REG_BRUSH_ALPHA: ba_r       <= cfg_wdata[CHW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: everything moves unless the output holds a stalled result.
  logic en;
  logic out_vld_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Stage A: offsets from the dab center.
  logic signed [CW-1:0] px, py;
  logic                 a_vld_r;
  side_t                a_side_r;
  logic signed [CW:0]   a_dx_r, a_dy_r;
  side_t                in_side;

  always_comb begin
    px              = in_tdata[CW-1:0];
    py              = in_tdata[2*CW-1:CW];
    in_side.dst_r   = in_tdata[2*CW+7:2*CW];
    in_side.dst_g   = in_tdata[2*CW+15:2*CW+8];
    in_side.dst_b   = in_tdata[2*CW+23:2*CW+16];
    in_side.dst_a   = in_tdata[2*CW+31:2*CW+24];
    in_side.written = !(px[CW-1] || py[CW-1]);
    in_side.mode    = OP_ZERO;
  end

  // Stage B: squares.  Stage C: radicand with the distance fraction bits.
  logic [2*CW-1:0] b_sqx_r, b_sqy_r;
  logic            b_vld_r, c_vld_r;
  side_t           b_side_r, c_side_r;
  logic [SQW-1:0]  c_rad_r;
  logic signed [2*CW+1:0] sqx_full, sqy_full;

  always_comb begin
    sqx_full = a_dx_r * a_dx_r;
    sqy_full = a_dy_r * a_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= in_side;
      a_dx_r   <= {center_x_r[CW-1], center_x_r} - {px[CW-1], px};
      a_dy_r   <= {center_y_r[CW-1], center_y_r} - {py[CW-1], py};
      b_side_r <= a_side_r;
      b_sqx_r  <= sqx_full[2*CW-1:0];
      b_sqy_r  <= sqy_full[2*CW-1:0];
      c_side_r <= b_side_r;
      c_rad_r  <= SQW'({1'b0, b_sqx_r} + {1'b0, b_sqy_r}) << (2 * RADIUS_FRAC_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Square root chain, one root bit per cell.
  logic            s_vld  [RW+1];
  side_t           s_side [RW+1];
  logic [RW+2:0]   s_rem  [RW+1];
  logic [RW-1:0]   s_root [RW+1];
  logic [SQW-1:0]  s_rad  [RW+1];

  assign s_vld[0]  = c_vld_r;
  assign s_side[0] = c_side_r;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_rad[0]  = c_rad_r;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    sbpb_sqrt_cell #(.RW(RW), .SQW(SQW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (s_vld[k]),
      .side_in (s_side[k]),
      .rem_in  (s_rem[k]),
      .root_in (s_root[k]),
      .rad_in  (s_rad[k]),
      .vld_r   (s_vld[k+1]),
      .side_r  (s_side[k+1]),
      .rem_r   (s_rem[k+1]),
      .root_r  (s_root[k+1]),
      .rad_r   (s_rad[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage D: fade position and the opacity case.
  logic signed [NW-1:0]   num;
  logic signed [RADW:0]   fade;
  op_mode_t               mode;
  side_t                  d_side_nxt;
  logic                   d_vld_r;
  side_t                  d_side_r;
  logic [RADW-1:0]        d_num_r, d_fade_r;

  always_comb begin
    num  = $signed(NW'(radius_r)) - $signed(NW'(s_root[RW]));
    fade = $signed({1'b0, radius_r}) - $signed({1'b0, hard_r});
    if (fade <= 0) begin
      mode = (num > 0) ? OP_ONE : OP_ZERO;
    end else if (num <= 0) begin
      mode = OP_ZERO;
    end else if (num >= NW'(fade)) begin
      mode = OP_ONE;
    end else begin
      mode = OP_DIV;
    end
    d_side_nxt      = s_side[RW];
    d_side_nxt.mode = mode;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= s_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side_r <= d_side_nxt;
      d_num_r  <= (mode == OP_DIV) ? num[RADW-1:0] : '0;
      d_fade_r <= fade[RADW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Divider chain, one opacity bit per cell.
  logic            q_vld  [F+1];
  side_t           q_side [F+1];
  logic [RADW-1:0] q_rem  [F+1];
  logic [RADW-1:0] q_fade [F+1];
  logic [F-1:0]    q_quot [F+1];

  assign q_vld[0]  = d_vld_r;
  assign q_side[0] = d_side_r;
  assign q_rem[0]  = d_num_r;
  assign q_fade[0] = d_fade_r;
  assign q_quot[0] = '0;

  for (genvar k = 0; k < F; k++) begin : g_div
    sbpb_div_cell #(.QW(F)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .vld_in  (q_vld[k]),
      .side_in (q_side[k]),
      .rem_in  (q_rem[k]),
      .fade_in (q_fade[k]),
      .quot_in (q_quot[k]),
      .vld_r   (q_vld[k+1]),
      .side_r  (q_side[k+1]),
      .rem_r   (q_rem[k+1]),
      .fade_r  (q_fade[k+1]),
      .quot_r  (q_quot[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Stage E: opacity times the color difference, per channel.
  logic [F:0]             op;
  side_t                  qs;
  logic                   e_vld_r;
  side_t                  e_side_r;
  logic signed [PW-1:0]   e_prod_r [4];
  logic [CHW-1:0]         src [4];
  logic [CHW-1:0]         dst [4];
  logic signed [CHW:0]    diff [4];
  logic signed [PW-1:0]   prod [4];

  always_comb begin
    qs = q_side[F];
    case (qs.mode)
      OP_ONE:  op = (F+1)'(1) << F;
      OP_DIV:  op = {1'b0, q_quot[F]};
      default: op = '0;
    endcase
    src[0] = br_r;  dst[0] = qs.dst_r;
    src[1] = bg_r;  dst[1] = qs.dst_g;
    src[2] = bb_r;  dst[2] = qs.dst_b;
    src[3] = ba_r;  dst[3] = qs.dst_a;
    for (int c = 0; c < 4; c++) begin
      diff[c] = $signed({1'b0, src[c]}) - $signed({1'b0, dst[c]});
      prod[c] = PW'(diff[c] * $signed({1'b0, op}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= q_vld[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= qs;
      for (int c = 0; c < 4; c++) begin
        e_prod_r[c] <= prod[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: add dst, round, take integer part; unwritten pixels pass dst.
  logic [CHW-1:0]        e_dst [4];
  logic signed [ACCW-1:0] acc [4];
  logic [CHW-1:0]        res [4];
  logic [4*CHW-1:0]      out_data_r;
  logic                  out_user_r;

  always_comb begin
    e_dst[0] = e_side_r.dst_r;
    e_dst[1] = e_side_r.dst_g;
    e_dst[2] = e_side_r.dst_b;
    e_dst[3] = e_side_r.dst_a;
    for (int c = 0; c < 4; c++) begin
      acc[c] = ACCW'(e_prod_r[c]) + $signed(ACCW'(e_dst[c]) << F)
             + $signed(ACCW'(1) << (F - 1));
      res[c] = e_side_r.written ? acc[c][F+CHW-1:F] : e_dst[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {res[3], res[2], res[1], res[0]};
      out_user_r <= e_side_r.written;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

// ===== src/sbpb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// sbpb_sqrt_cell
// One stage of the square root chain: settles one root bit per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpb_sqrt_cell
  import sbpb_pkg::*;
#(
  parameter int RW  = 18,
  parameter int SQW = 36
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           vld_in,
  input  wire side_t          side_in,
  input  wire logic [RW+2:0]  rem_in,
  input  wire logic [RW-1:0]  root_in,
  input  wire logic [SQW-1:0] rad_in,
  output logic                vld_r,
  output side_t               side_r,
  output logic [RW+2:0]       rem_r,
  output logic [RW-1:0]       root_r,
  output logic [SQW-1:0]      rad_r
);

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic          fits;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_in[RW:0], rad_in[SQW-1:SQW-2]};
    trial  = {1'b0, root_in, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      rad_r  <= rad_in << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_in[RW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== src/sbpb_div_cell.sv =====
// ----------------------------------------------------------------------------
// sbpb_div_cell
// One stage of the opacity divider: settles one quotient bit per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpb_div_cell
  import sbpb_pkg::*;
#(
  parameter int QW = 12
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_in,
  input  wire side_t           side_in,
  input  wire logic [RADW-1:0] rem_in,
  input  wire logic [RADW-1:0] fade_in,
  input  wire logic [QW-1:0]   quot_in,
  output logic                 vld_r,
  output side_t                side_r,
  output logic [RADW-1:0]      rem_r,
  output logic [RADW-1:0]      fade_r,
  output logic [QW-1:0]        quot_r
);

  logic [RADW:0] rem_sh;
  logic          fits;

  // Remainder stays below the divisor, so the doubled value fits one more bit.
  always_comb begin
    rem_sh = {rem_in, 1'b0};
    fits   = (rem_sh >= {1'b0, fade_in});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      fade_r <= fade_in;
      rem_r  <= fits ? RADW'(rem_sh - {1'b0, fade_in}) : RADW'(rem_sh);
      quot_r <= {quot_in[QW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== src/sbpb_checker.sv =====
// ----------------------------------------------------------------------------
// sbpb_checker
// Port level checks of the soft brush pixel blend.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tuser
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The pipeline takes no new request while its output is blocked.
  a_stall_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken while output blocked");

  // Reset empties the pipeline, so it comes out ready and with no result.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

endmodule

bind soft_brush_pixel_blend sbpb_checker u_sbpb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== tb/soft_brush_pixel_blend_tb.sv =====
// ----------------------------------------------------------------------------
// Soft brush pixel blend testbench
// Streams pixel requests through the brush blend under random flow control,
// predicts every blended pixel from the brush registers and checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import sbpb_pkg::*;

// Holds the brush settings, predicts blended pixels and checks the results.
class blend_scoreboard;
  logic signed [12:0] cx, cy;
  logic [13:0] rad, hard;
  logic [7:0] brush [4];
  logic [32:0] pending [$];
  int errors;
  int checked;

  function new();
    cx = '0;
    cy = '0;
    rad = RADIUS_RST;
    hard = HARD_RADIUS_RST;
    brush[0] = BRUSH_RED_RST;
    brush[1] = BRUSH_GREEN_RST;
    brush[2] = BRUSH_BLUE_RST;
    brush[3] = BRUSH_ALPHA_RST;
    errors = 0;
    checked = 0;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [13:0] val);
    case (idx)
      REG_CENTER_X: cx = val[12:0];
      REG_CENTER_Y: cy = val[12:0];
      REG_RADIUS: rad = val;
      REG_HARD_RADIUS: hard = val;
      REG_BRUSH_RED: brush[0] = val[7:0];
      REG_BRUSH_GREEN: brush[1] = val[7:0];
      REG_BRUSH_BLUE: brush[2] = val[7:0];
      REG_BRUSH_ALPHA: brush[3] = val[7:0];
      default: ;
    endcase
  endfunction

  // Floor of the square root, bit by bit.
  function longint isqrt(longint n);
    longint root, b;
    root = 0;
    b = 64'd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >>> 1) + b;
      end else begin
        root = root >>> 1;
      end
      b = b >>> 2;
    end
    return isqrt_ret(root);
  endfunction

  function longint isqrt_ret(longint r);
    return r;
  endfunction

  // Notes one accepted pixel request and queues its blended pixel.
  function void note_pixel(logic [57:0] d);
    logic signed [12:0] px, py;
    longint dx, dy, distance, num, fade, op, acc, s, dv;
    logic [31:0] res;
    px = d[12:0];
    py = d[25:13];
    if (px < 0 || py < 0) begin
      pending.push_back({1'b0, d[57:26]});
      return;
    end
    dx = longint'(cx) - longint'(px);
    dy = longint'(cy) - longint'(py);
    distance = isqrt((dx * dx + dy * dy) * 256);
    num = longint'(rad) - distance;
    fade = longint'(rad) - longint'(hard);
    if (fade <= 0) op = (num > 0) ? 4096 : 0;
    else if (num <= 0) op = 0;
    else if (num >= fade) op = 4096;
    else op = (num * 4096) / fade;
    for (int c = 0; c < 4; c++) begin
      s = brush[c];
      dv = d[26 + 8 * c +: 8];
      acc = (s - dv) * op + dv * 4096 + 2048;
      if (acc < 0) acc = 0;
      res[8 * c +: 8] = acc[19:12];
    end
    pending.push_back({1'b1, res});
  endfunction

  function void report(string what, logic [32:0] got, logic [32:0] want);
    $display("ERROR %s: got %h expected %h", what, got, want);
    errors++;
  endfunction

  // Compares one accepted result with the oldest prediction.
  function void check_pixel(logic [31:0] data, logic wr);
    logic [32:0] want;
    if (pending.size() == 0) begin
      report("unexpected result", {wr, data}, 33'h0);
      return;
    end
    want = pending.pop_front();
    checked++;
    for (int c = 0; c < 4; c++)
      if (data[8 * c +: 8] !== want[8 * c +: 8])
        report($sformatf("channel %0d", c), {wr, data}, want);
    if (wr !== want[32]) report("written flag", {wr, data}, want);
  endfunction
endclass

module soft_brush_pixel_blend_tb;
  localparam int LIMIT = 5000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_wdata = '0;

  blend_scoreboard sb = new();
  bit idle_on = 1;
  int quiet;
  int sent;
  int written_cnt;

  always #6 clk = ~clk;

  soft_brush_pixel_blend uut (.*);

  // Result side: random stalls while idle_on is set, check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_pixel(out_tdata, out_tuser);
      if (out_tuser) written_cnt++;
    end
    out_tready <= idle_on ? ($urandom_range(99) >= 30) : 1'b1;
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= LIMIT) begin
      $display("Timeout with %0d results pending", sb.pending.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // One register write; the write enable then goes low again before the scoreboard takes the value.
  task automatic write_reg(cfg_reg_t idx, logic [13:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Sends one pixel request and waits for it to be taken.
  task automatic send_pixel(logic signed [12:0] x, logic signed [12:0] y, logic [31:0] rgba);
    while (idle_on && $urandom_range(99) < 30) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {6'b0, rgba, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_pixel({rgba, y, x});
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Pixels mostly near the brush center, some anywhere, some negative.
  task automatic random_pixels(int n, int spread);
    logic signed [12:0] x, y;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin x = 13'($urandom); y = 13'($urandom); end
        1: begin x = 13'(-$urandom_range(4096, 1)); y = 13'($urandom); end
        default: begin
          x = 13'(sb.cx + $signed($urandom_range(2 * spread)) - spread);
          y = 13'(sb.cy + $signed($urandom_range(2 * spread)) - spread);
        end
      endcase
      send_pixel(x, y, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // Reset settings: extremes of position and channels, the rim of the dab.
    send_pixel(13'sd0, 13'sd0, 32'h0000_0000);
    send_pixel(13'sd0, 13'sd0, 32'hFFFF_FFFF);
    send_pixel(13'sd5, 13'sd0, 32'h8040_20FF);
    send_pixel(13'sd4, 13'sd3, 32'h1234_5678);
    send_pixel(13'sd3, 13'sd3, 32'hA5A5_5A5A);
    send_pixel(13'sd4095, 13'sd4095, 32'hFFFF_0000);
    send_pixel(-13'sd4096, 13'sd0, 32'hDEAD_BEEF);
    send_pixel(13'sd0, -13'sd1, 32'hCAFE_F00D);
    send_pixel(-13'sd1, -13'sd4096, 32'h0102_0304);
    drain();

    // Hard edge with no fade, center at the far corner.
    write_reg(REG_CENTER_X, 14'h0FFF);
    write_reg(REG_CENTER_Y, 14'h0FFF);
    write_reg(REG_RADIUS, 14'd160);
    write_reg(REG_HARD_RADIUS, 14'd200);
    write_reg(REG_BRUSH_RED, 14'd255);
    write_reg(REG_BRUSH_GREEN, 14'd0);
    write_reg(REG_BRUSH_BLUE, 14'd128);
    write_reg(REG_BRUSH_ALPHA, 14'd0);
    send_pixel(13'sd4095, 13'sd4085, 32'h0000_0000);
    send_pixel(13'sd4095, 13'sd4086, 32'hFFFF_FFFF);
    send_pixel(13'sd4089, 13'sd4087, 32'h7777_7777);
    random_pixels(90, 14);
    drain();

    // Negative center, zero radius, so nothing is painted.
    write_reg(REG_CENTER_X, 14'h1000);
    write_reg(REG_CENTER_Y, 14'h1F00);
    write_reg(REG_RADIUS, 14'd0);
    write_reg(REG_HARD_RADIUS, 14'd0);
    random_pixels(60, 30);
    drain();

    // Widest radius with a soft fade, long run without idling.
    write_reg(REG_CENTER_X, 14'd100);
    write_reg(REG_CENTER_Y, 14'd200);
    write_reg(REG_RADIUS, 14'h3FFF);
    write_reg(REG_HARD_RADIUS, 14'd3000);
    write_reg(REG_BRUSH_ALPHA, 14'd255);
    idle_on = 0;
    random_pixels(150, 1100);
    drain();
    idle_on = 1;

    // Random settings with small brushes, soft or hard.
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_CENTER_X, 14'($urandom_range(300)));
      write_reg(REG_CENTER_Y, 14'($urandom_range(300)));
      write_reg(REG_RADIUS, 14'($urandom_range(400)));
      write_reg(REG_HARD_RADIUS, 14'($urandom_range(200)));
      write_reg(REG_BRUSH_RED, 14'($urandom));
      write_reg(REG_BRUSH_GREEN, 14'($urandom));
      write_reg(REG_BRUSH_BLUE, 14'($urandom));
      write_reg(REG_BRUSH_ALPHA, 14'($urandom));
      random_pixels(50, 28);
      drain();
    end

    $display("Sent %0d pixels, checked %0d, %0d of them inside the image.",
             sent, sb.checked, written_cnt);
    $display("Covered hard and soft edges, empty and widest brushes, negative positions.");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
